@@ rtl/ebrc_pkg.sv @@
// Shared types and codes for the eight-bit RISC core step block.
`timescale 1ns / 1ps

package ebrc_pkg;

  localparam int RF_DEPTH = 8;

  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_J     = 4'd2;
  localparam logic [3:0] OP_JAL   = 4'd3;
  localparam logic [3:0] OP_ADDI  = 4'd4;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_LW    = 4'd11;
  localparam logic [3:0] OP_SW    = 4'd15;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVF     = 2'd1,
    ST_RANGE   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef logic [2:0]        reg_idx_t;
  typedef logic signed [7:0] word_t;

  // packed from the top bit down, so next_pc lands in bits 7:0
  typedef struct packed {
    logic     pad;
    status_t  status;
    logic [7:0] mem_address;
    logic     mem_written;
    word_t    dest_value;
    reg_idx_t dest_reg;
    logic     reg_written;
    logic [7:0] next_pc;
  } result_t;

endpackage

@@ rtl/eight_bit_risc_core_step.sv @@
// Eight-bit RISC core step: decode, execute and write back one instruction word per cycle while output is taken.
`timescale 1ns / 1ps

// One instruction word in, one result word out, at up to one word per clock.
// An accepted word sits in the input register together with its two source
// operands, which are read from the register file as the word is taken; the
// ALU, address check, branch and jump logic then run on it, and the result
// register is loaded when the output is empty or taken. A load's data comes
// from the data memory's registered read port alongside the result register,
// and each register write is committed in the cycle after its result is
// produced, with bypassing into the operands of the following word.
// out_tvalid rises when the word moves from the input register into the result
// register; throughput is one word per cycle while the output is taken.
// Reset clears the registers, the program counter and the data memory's valid
// bits, so the memory reads as zero until written; no clearing pass is needed.
module eight_bit_risc_core_step #(
  parameter int DATA_DEPTH    = 256,
  parameter int PROGRAM_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // instruction[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // next_pc[7:0], reg_written[8], dest_reg[11:9],
                                  // dest_value[19:12], mem_written[20],
                                  // mem_address[28:21], status[30:29], zero[31]
);
  import ebrc_pkg::*;

  localparam int PC_LIMIT = (PROGRAM_DEPTH > 256) ? 256 : PROGRAM_DEPTH;
  localparam int MEM_AW   = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam logic [8:0]  PC_LIM_9  = 9'(PC_LIMIT);
  localparam logic [9:0]  PC_LIM_10 = 10'(PC_LIMIT);
  localparam logic [12:0] PC_LIM_13 = 13'(PC_LIMIT);
  localparam logic [9:0]  DEPTH_10  = 10'(DATA_DEPTH);

  // input stage
  logic        in_vld_r;
  logic [15:0] ins_r;
  word_t       a_r, b_r;
  word_t       a_nxt, b_nxt;

  // result stage
  logic        out_vld_r;
  result_t     res_r;
  logic        res_load_r;
  logic        wb_pend_r;

  // architectural state
  word_t       rf_r [RF_DEPTH];
  logic [7:0]  pc_r;
  logic [7:0]  mem_r [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] mem_vld_r;
  logic [7:0]  mem_q_r;
  logic        mem_q_vld_r;

  logic        fire, in_acc;
  word_t       dest_val;
  reg_idx_t    wb_idx;

  logic [3:0]  opc;
  reg_idx_t    rs, rt, rd, rs_in, rt_in;
  logic [2:0]  fn;
  logic [11:0] target;
  logic [5:0]  imm;
  word_t       op_a, op_b;

  logic [8:0]  pc_inc, sum_ab, dif_ab, sum_ai;
  logic [9:0]  br_tgt;
  logic [7:0]  seq_pc;
  logic        addr_ok, br_ok, jmp_ok;
  logic [MEM_AW-1:0] mem_idx;

  result_t     res_c, out_c;
  logic        load_c, store_c;

  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  assign dest_val = res_load_r ? (mem_q_vld_r ? word_t'(mem_q_r) : '0) : res_r.dest_value;
  assign wb_idx   = res_r.dest_reg;

  assign opc    = ins_r[15:12];
  assign rs     = ins_r[11:9];
  assign rt     = ins_r[8:6];
  assign rd     = ins_r[5:3];
  assign fn     = ins_r[2:0];
  assign target = ins_r[11:0];
  assign imm    = ins_r[5:0];
  assign rs_in  = in_tdata[11:9];
  assign rt_in  = in_tdata[8:6];

  // bypass the write that commits this cycle
  assign op_a = (wb_pend_r && wb_idx == rs) ? dest_val : a_r;
  assign op_b = (wb_pend_r && wb_idx == rt) ? dest_val : b_r;

  always_comb begin
    if (in_acc) begin
      a_nxt = (wb_pend_r && wb_idx == rs_in) ? dest_val : rf_r[rs_in];
      b_nxt = (wb_pend_r && wb_idx == rt_in) ? dest_val : rf_r[rt_in];
    end else begin
      a_nxt = op_a;
      b_nxt = op_b;
    end
  end

  assign pc_inc = {1'b0, pc_r} + 9'd1;
  assign seq_pc = (pc_inc >= PC_LIM_9) ? 8'd0 : pc_inc[7:0];
  assign sum_ab = {op_a[7], op_a} + {op_b[7], op_b};
  assign dif_ab = {op_a[7], op_a} - {op_b[7], op_b};
  assign sum_ai = {op_a[7], op_a} + {{3{imm[5]}}, imm};
  assign br_tgt = {2'b00, pc_r} + {{4{imm[5]}}, imm};
  assign addr_ok = !sum_ai[8] && ({2'b00, sum_ai[7:0]} < DEPTH_10);
  assign br_ok   = !br_tgt[9] && (br_tgt < PC_LIM_10);
  assign jmp_ok  = {1'b0, target} < PC_LIM_13;
  assign mem_idx = sum_ai[MEM_AW-1:0];

  always_comb begin
    res_c         = '0;
    res_c.next_pc = seq_pc;
    res_c.status  = ST_OK;
    load_c        = 1'b0;
    store_c       = 1'b0;
    case (opc)
      OP_RTYPE: begin
        case (fn)
          FN_ADD: begin
            if (sum_ab[8] != sum_ab[7]) begin
              res_c.status = ST_OVF;
            end else begin
              res_c.reg_written = 1'b1;
              res_c.dest_reg    = rd;
              res_c.dest_value  = word_t'(sum_ab[7:0]);
            end
          end
          FN_SUB: begin
            if (dif_ab[8] != dif_ab[7]) begin
              res_c.status = ST_OVF;
            end else begin
              res_c.reg_written = 1'b1;
              res_c.dest_reg    = rd;
              res_c.dest_value  = word_t'(dif_ab[7:0]);
            end
          end
          FN_AND: begin
            res_c.reg_written = 1'b1;
            res_c.dest_reg    = rd;
            res_c.dest_value  = op_a & op_b;
          end
          FN_OR: begin
            res_c.reg_written = 1'b1;
            res_c.dest_reg    = rd;
            res_c.dest_value  = op_a | op_b;
          end
          default: res_c.status = ST_UNKNOWN;
        endcase
      end
      OP_J, OP_JAL: begin
        if (jmp_ok) begin
          res_c.next_pc = target[7:0];
        end else begin
          res_c.status = ST_RANGE;
        end
      end
      OP_ADDI: begin
        if (sum_ai[8] != sum_ai[7]) begin
          res_c.status = ST_OVF;
        end else begin
          res_c.reg_written = 1'b1;
          res_c.dest_reg    = rt;
          res_c.dest_value  = word_t'(sum_ai[7:0]);
        end
      end
      OP_LW: begin
        if (addr_ok) begin
          res_c.mem_address = sum_ai[7:0];
          res_c.reg_written = 1'b1;
          res_c.dest_reg    = rt;
          load_c            = 1'b1;
        end else begin
          res_c.status = ST_RANGE;
        end
      end
      OP_SW: begin
        if (addr_ok) begin
          res_c.mem_address = sum_ai[7:0];
          res_c.mem_written = 1'b1;
          store_c           = 1'b1;
        end else begin
          res_c.status = ST_RANGE;
        end
      end
      OP_BEQ: begin
        if (op_a == op_b) begin
          if (br_ok) begin
            res_c.next_pc = br_tgt[7:0];
          end else begin
            res_c.status = ST_RANGE;
          end
        end
      end
      default: res_c.status = ST_UNKNOWN;
    endcase
  end

  always_comb begin
    out_c            = res_r;
    out_c.dest_value = dest_val;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_c;

  // control, register file, pc and data memory valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      wb_pend_r  <= 1'b0;
      res_load_r <= 1'b0;
      pc_r       <= '0;
      mem_vld_r  <= '0;
      for (int i = 0; i < RF_DEPTH; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r  <= 1'b1;
        res_load_r <= load_c;
        pc_r       <= res_c.next_pc;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      wb_pend_r <= fire && res_c.reg_written;
      if (wb_pend_r) begin
        rf_r[wb_idx] <= dest_val;
      end
      if (fire && store_c) begin
        mem_vld_r[mem_idx] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ins_r <= in_tdata;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (fire) begin
      res_r <= res_c;
    end
  end

  // data memory, registered read
  always_ff @(posedge clk) begin
    if (fire && store_c) begin
      mem_r[mem_idx] <= op_b;
    end
    if (fire && load_c) begin
      mem_q_r     <= mem_r[mem_idx];
      mem_q_vld_r <= mem_vld_r[mem_idx];
    end
  end

  a_wb_follows_fire: assert property (@(posedge clk) disable iff (!rst_n)
    wb_pend_r |-> $past(fire) && out_vld_r && res_r.reg_written)
    else $error("register write-back without a produced result");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("result register not loaded after execute");

  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.status != ST_OK |-> !res_r.reg_written && !res_r.mem_written)
    else $error("faulting word caused a write");

  a_one_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.reg_written && res_r.mem_written))
    else $error("register and memory written by one word");

  a_load_sets_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_load_r |-> res_r.reg_written && !res_r.mem_written)
    else $error("load result without register write");

endmodule
